@@ sv/cwis_pkg.sv @@
// package of shared types and constants for the cumulative weight index search
package cwis_pkg;

    // default table depth
    localparam int unsigned PARTICLE_COUNT_DEF = 1024;

    // field widths of the stream payloads
    localparam int unsigned CMD_W      = 1;
    localparam int unsigned INDEX_W    = 10;
    localparam int unsigned WEIGHT_W   = 32;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned PROD_W     = WEIGHT_W + FRAC_W;
    localparam int unsigned S_TDATA_W  = 64;
    localparam int unsigned M_TDATA_W  = 16;

    // bit positions inside the slave tdata
    localparam int unsigned IDX_LSB    = 0;
    localparam int unsigned WGT_LSB    = IDX_LSB + INDEX_W;
    localparam int unsigned FRAC_LSB   = WGT_LSB + WEIGHT_W;

    // command codes carried in tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // search sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_FIRST,
        S_SECOND,
        S_SEARCH,
        S_DONE
    } t_state;

endpackage

@@ sv/cwis_mem.sv @@
// weight table with separate write and read ports and a registered read
module cwis_mem #(
    parameter int unsigned DEPTH  = cwis_pkg::PARTICLE_COUNT_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [ADDR_W-1:0]             i_wr_addr,
    input  logic [cwis_pkg::WEIGHT_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]             i_rd_addr,
    output logic [cwis_pkg::WEIGHT_W-1:0] o_rd_data
);
    import cwis_pkg::*;

    logic [WEIGHT_W-1:0] r_mem [DEPTH];
    logic [WEIGHT_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/cumulative_weight_index_search.sv @@
// top level: roulette wheel selection by binary search over cumulative weights
// A load transaction (tuser = 0) writes one cumulative weight into the table; loads
// at or beyond PARTICLE_COUNT are dropped. A query transaction (tuser = 1) scales
// the last table entry by the 16-bit random fraction and returns the smallest index
// whose weight reaches that target, or the last index if none.
// A query occupies the block while it reads the table through its single read port:
// one read for the last entry, one each for the first and next-to-last entries, then
// one read per bisection step. The result sits in an output register, so the next
// transaction is taken while it waits to be consumed; a later query that finishes
// while that register is still full holds in its done state, with the input stalled,
// until the receiver takes the waiting result.
// The table has no reset; entries must be loaded before a query reads them.
module cumulative_weight_index_search #(
    parameter int unsigned PARTICLE_COUNT = cwis_pkg::PARTICLE_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: entry_index[9:0], entry_weight[41:10], random_fraction[57:42], zero pad
    input  logic [cwis_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: cmd[0]
    input  logic [cwis_pkg::CMD_W-1:0]     s_axis_tuser,
    // master side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: selected_index[9:0], zero pad
    output logic [cwis_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import cwis_pkg::*;

    localparam int unsigned ADDR_W = $clog2(PARTICLE_COUNT);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(PARTICLE_COUNT - 1);
    localparam logic [ADDR_W-1:0] PREV_IDX = ADDR_W'(PARTICLE_COUNT - 2);

    t_state              r_state, n_state;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic [WEIGHT_W-1:0] r_target, n_target;
    logic [ADDR_W-1:0]   r_lo, n_lo;
    logic [ADDR_W-1:0]   r_hi, n_hi;
    logic [ADDR_W-1:0]   r_result, n_result;
    logic                r_out_valid, n_out_valid;
    logic [INDEX_W-1:0]  r_out_idx, n_out_idx;

    logic                w_accept;
    logic [INDEX_W-1:0]  w_in_idx;
    logic [WEIGHT_W-1:0] w_in_wgt;
    logic [FRAC_W-1:0]   w_in_frac;
    logic [31:0]         w_in_idx_ext;
    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [WEIGHT_W-1:0] w_rd_data;
    logic [PROD_W-1:0]   w_prod;
    logic [ADDR_W-1:0]   w_mid;
    logic [ADDR_W-1:0]   w_step_lo;
    logic [ADDR_W-1:0]   w_step_hi;
    logic [ADDR_W-1:0]   w_step_mid;
    logic [31:0]         w_result_ext;

    // unpack the slave payload
    assign w_in_idx     = s_axis_tdata[IDX_LSB +: INDEX_W];
    assign w_in_wgt     = s_axis_tdata[WGT_LSB +: WEIGHT_W];
    assign w_in_frac    = s_axis_tdata[FRAC_LSB +: FRAC_W];
    assign w_in_idx_ext = 32'(w_in_idx);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // table write on an in-range load
    assign w_wr_en   = w_accept && (t_cmd'(s_axis_tuser) == CMD_LOAD)
                       && (w_in_idx_ext < 32'(PARTICLE_COUNT));
    assign w_wr_addr = w_in_idx_ext[ADDR_W-1:0];

    // target scaling: fraction times last entry, upper bits kept
    assign w_prod = PROD_W'(r_frac) * PROD_W'(w_rd_data);

    // bisection step with lower middle
    assign w_mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign w_step_lo  = (r_target > w_rd_data) ? (w_mid + ADDR_W'(1)) : r_lo;
    assign w_step_hi  = (r_target > w_rd_data) ? r_hi : w_mid;
    assign w_step_mid = w_step_lo + ((w_step_hi - w_step_lo) >> 1);

    cwis_mem #(
        .DEPTH  (PARTICLE_COUNT),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_in_wgt),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_result_ext = 32'(r_result);

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_frac      = r_frac;
        n_target    = r_target;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        n_out_idx   = r_out_idx;
        w_rd_addr   = LAST_IDX;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                w_rd_addr = LAST_IDX;
                if (w_accept && (t_cmd'(s_axis_tuser) == CMD_QUERY)) begin
                    n_frac  = w_in_frac;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_target  = w_prod[PROD_W-1 -: WEIGHT_W];
                w_rd_addr = '0;
                n_state   = S_FIRST;
            end
            S_FIRST: begin
                w_rd_addr = PREV_IDX;
                if (r_target <= w_rd_data) begin
                    n_result = '0;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SECOND;
                end
            end
            S_SECOND: begin
                n_lo      = '0;
                n_hi      = LAST_IDX;
                w_rd_addr = LAST_IDX >> 1;
                if (r_target > w_rd_data) begin
                    n_result = LAST_IDX;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_lo      = w_step_lo;
                n_hi      = w_step_hi;
                w_rd_addr = w_step_mid;
                if (w_step_lo >= w_step_hi) begin
                    n_result = w_step_hi;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = w_result_ext[INDEX_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_frac    <= n_frac;
        r_target  <= n_target;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_result  <= n_result;
        r_out_idx <= n_out_idx;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_idx);

    // search bounds stay ordered while bisecting
    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> ((r_lo < r_hi) && (r_hi <= LAST_IDX)))
        else $error("bisection bounds out of order");

    // an accepted query starts with the last entry read
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_cmd'(s_axis_tuser) == CMD_QUERY)) |=> (r_state == S_LAST))
        else $error("query did not start the search");

    // a new result only appears out of the done state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

    // no table write while a search is in flight
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_IDLE))
        else $error("table written during a search");

endmodule
